// ===== rtl/core/sha1md_pkg.sv =====
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned SCHED_LEN  = 16;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_MID,
        PH_FINAL
    } phase_t;

    typedef struct packed {
        logic       wr_byte;
        logic [7:0] byte_val;
        logic       pad;
        logic       zero_low;
        logic       ins_len;
        logic       load_work;
        logic       round_en;
        logic [6:0] round;
        logic       add_chain;
        logic       load_dig;
    } cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       out_busy;
    } sts_t;

endpackage

// ===== rtl/core/sha1_message_digest.sv =====
// SHA-1 message digest: byte stream in, five 32-bit digest words out.
//
// Input channel (s_*): one request per item. s_tdata[7:0] is the message byte,
// valid only when s_tuser is high; s_tlast ends the message (it may carry no byte).
// Output channel (m_*): five requests per message, m_tdata[31:0] the digest word
// (big-endian), m_tdata[34:32] its index 0..4, m_tlast on the fifth word.
//
// Timing: a byte that does not complete a 64-byte block is taken in the idle state
// and leaves the input ready. A byte that completes a block runs the single shared
// round unit through 80 rounds and an add step, and the input is ready again only
// after the add. An end request adds a pad step, 80 rounds and an add (plus a
// length step, 80 rounds and an add when fewer than 9 bytes of room remain), then a
// done step that hands the digest over. Byte intake and the one-round-per-cycle unit
// do not overlap: no byte is taken while a block is being compressed.
//
// The digest sits in its own output register, so the next message is accepted while
// it drains; a message that ends before the previous digest is taken waits for it.
// Reset clears the chaining words to the standard initial values and the byte count.
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);

    sha1md_pkg::cmd_t cmd;
    sha1md_pkg::sts_t sts;

    sha1md_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    sha1md_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/sha1md_ctrl.sv =====
// Controller state machine: sequences byte writes, padding, rounds and digest hand-off.
module sha1md_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // has_byte
    input  logic                s_tlast,   // end_of_message
    input  sha1md_pkg::sts_t    sts,
    output sha1md_pkg::cmd_t    cmd
);

    sha1md_pkg::state_t state_reg, state_next;
    sha1md_pkg::phase_t phase_reg, phase_next;
    logic [6:0]         round_reg, round_next;
    logic               fin_reg, fin_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1md_pkg::ST_IDLE;
            phase_reg <= sha1md_pkg::PH_DATA;
            round_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        fin_next   = fin_reg;
        s_tready   = 1'b0;
        cmd          = '0;
        cmd.byte_val = s_tdata;
        cmd.round    = round_reg;

        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.wr_byte = s_tuser;
                    if (s_tuser && sts.pos == sha1md_pkg::LAST_POS)
                    begin
                        // block just filled: compress it, remember the end flag
                        cmd.load_work = 1'b1;
                        fin_next   = s_tlast;
                        phase_next = sha1md_pkg::PH_DATA;
                        round_next = '0;
                        state_next = sha1md_pkg::ST_COMP;
                    end
                    else if (s_tlast)
                    begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                cmd.pad       = 1'b1;
                cmd.load_work = 1'b1;
                round_next    = '0;
                if (sts.pos >= sha1md_pkg::LEN_POS)
                begin
                    // no room for the length: it goes into an extra block
                    phase_next = sha1md_pkg::PH_MID;
                end
                else
                begin
                    cmd.ins_len = 1'b1;
                    phase_next  = sha1md_pkg::PH_FINAL;
                end
                state_next = sha1md_pkg::ST_COMP;
            end
            sha1md_pkg::ST_LEN:
            begin
                cmd.zero_low  = 1'b1;
                cmd.ins_len   = 1'b1;
                cmd.load_work = 1'b1;
                round_next    = '0;
                phase_next    = sha1md_pkg::PH_FINAL;
                state_next    = sha1md_pkg::ST_COMP;
            end
            sha1md_pkg::ST_COMP:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 7'd1;
                if (round_reg == sha1md_pkg::LAST_ROUND)
                begin
                    state_next = sha1md_pkg::ST_ADD;
                end
            end
            sha1md_pkg::ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                case (phase_reg)
                    sha1md_pkg::PH_DATA:
                        state_next = fin_reg ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
                    sha1md_pkg::PH_MID:
                        state_next = sha1md_pkg::ST_LEN;
                    sha1md_pkg::PH_FINAL:
                        state_next = sha1md_pkg::ST_DONE;
                    default:
                        state_next = sha1md_pkg::ST_IDLE;
                endcase
            end
            sha1md_pkg::ST_DONE:
            begin
                // wait until the previous digest has fully left the output
                if (!sts.out_busy)
                begin
                    cmd.load_dig = 1'b1;
                    fin_next     = 1'b0;
                    state_next   = sha1md_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::ST_COMP) |-> (round_reg <= sha1md_pkg::LAST_ROUND))
        else $error("round counter past last round");
    a_comp_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::ST_COMP && round_reg == sha1md_pkg::LAST_ROUND)
        |=> (state_reg == sha1md_pkg::ST_ADD))
        else $error("compression did not end in the add step");
`endif

endmodule

// ===== rtl/core/sha1md_dp.sv =====
// Datapath: block buffer / message schedule, round logic, chaining words and digest output.
module sha1md_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1md_pkg::cmd_t    cmd,
    output sha1md_pkg::sts_t    sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                m_tlast    // last_word
);

    // sched_reg[i] holds w[r+i] during round r; before round 0 it is the block buffer
    logic [31:0] sched_reg  [sha1md_pkg::SCHED_LEN];
    logic [31:0] sched_next [sha1md_pkg::SCHED_LEN];
    logic [31:0] chain_reg  [sha1md_pkg::NUM_WORDS];
    logic [31:0] chain_next [sha1md_pkg::NUM_WORDS];
    logic [31:0] dig_reg    [sha1md_pkg::NUM_WORDS];
    logic [31:0] dig_next   [sha1md_pkg::NUM_WORDS];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [60:0] count_reg, count_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_busy_reg, out_busy_next;

    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [31:0] f_val, k_val, w_mix, w_new, t_val;
    logic        out_take;

    assign pos      = count_reg[5:0];
    assign bit_len  = {count_reg, 3'b000};
    assign out_take = out_busy_reg && m_tready;

    assign sts.pos      = pos;
    assign sts.out_busy = out_busy_reg;

    assign m_tvalid = out_busy_reg;
    assign m_tdata  = {5'b00000, out_idx_reg, dig_reg[0]};
    assign m_tlast  = (out_idx_reg == sha1md_pkg::LAST_IDX);

    always_comb
    begin
        if (cmd.round < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1md_pkg::K_R0;
        end
        else if (cmd.round < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_R1;
        end
        else if (cmd.round < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1md_pkg::K_R2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1md_pkg::K_R3;
        end
        w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + sched_reg[0];
    end

    always_comb
    begin
        sched_next = sched_reg;
        chain_next = chain_reg;
        dig_next   = dig_reg;
        count_next = count_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        out_idx_next  = out_idx_reg;
        out_busy_next = out_busy_reg;

        if (cmd.wr_byte)
        begin
            // big-endian: byte lane 0 is the top byte of the word
            sched_next[pos[5:2]][(5'(3 - pos[1:0]) * 5'd8) +: 8] = cmd.byte_val;
            count_next = count_reg + 61'd1;
        end

        if (cmd.pad)
        begin
            for (int j = 0; j < sha1md_pkg::SCHED_LEN; j++)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (6'(4 * j + b) == pos)
                        sched_next[j][(31 - 8 * b) -: 8] = sha1md_pkg::PAD_BYTE;
                    else if (6'(4 * j + b) > pos)
                        sched_next[j][(31 - 8 * b) -: 8] = 8'h00;
                end
            end
        end

        if (cmd.zero_low)
        begin
            for (int j = 0; j < sha1md_pkg::SCHED_LEN - 2; j++)
            begin
                sched_next[j] = '0;
            end
        end

        if (cmd.ins_len)
        begin
            sched_next[14] = bit_len[63:32];
            sched_next[15] = bit_len[31:0];
        end

        if (cmd.load_work)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end

        if (cmd.round_en)
        begin
            for (int j = 0; j < sha1md_pkg::SCHED_LEN - 1; j++)
            begin
                sched_next[j] = sched_reg[j + 1];
            end
            sched_next[sha1md_pkg::SCHED_LEN - 1] = w_new;
            a_next = t_val;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end

        if (cmd.add_chain)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end

        if (out_take)
        begin
            for (int j = 0; j < sha1md_pkg::NUM_WORDS - 1; j++)
            begin
                dig_next[j] = dig_reg[j + 1];
            end
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == sha1md_pkg::LAST_IDX)
                out_busy_next = 1'b0;
        end

        if (cmd.load_dig)
        begin
            dig_next      = chain_reg;
            chain_next    = sha1md_pkg::H_INIT;
            count_next    = '0;
            out_idx_next  = '0;
            out_busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg    <= sha1md_pkg::H_INIT;
            count_reg    <= '0;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
        end
        else
        begin
            chain_reg    <= chain_next;
            count_reg    <= count_next;
            out_idx_reg  <= out_idx_next;
            out_busy_reg <= out_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        dig_reg   <= dig_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
    end

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_idx_reg <= sha1md_pkg::LAST_IDX))
        else $error("digest word index out of range");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_dig |-> !out_busy_reg)
        else $error("new digest loaded over one still being sent");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output still valid after last digest word");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the SHA-1 message digest block.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 1500;
    localparam int TAIL_CYCLES = 200;
    localparam int NUM_ITEMS   = 320;
    localparam int NUM_DIR     = 15;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    // want: five digest words, word 0 in the top bits; zero means use the predictor
    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic [159:0] want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic [31:0] chain_h [5];
    logic [7:0]  blk_buf [64];
    logic [60:0] msg_len;

    digest_word_t digest_q [$];
    int n_items  = 0;
    int n_words  = 0;
    int n_errors = 0;
    int idle_cnt = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit held     = 1'b0;

    stim_row_t dir_tab [NUM_DIR] = '{
        '{8'h00, 1'b0, 1'b0, 160'h0},       // no byte, no end: ignored
        '{8'hFF, 1'b0, 1'b1,                // empty message right after reset
          160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
        '{8'h61, 1'b1, 1'b0, 160'h0},
        '{8'h62, 1'b1, 1'b0, 160'h0},
        '{8'h63, 1'b1, 1'b1,                // "abc", last byte rides on the end request
          160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
        '{8'h5A, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b0, 160'h0},
        '{8'hAA, 1'b0, 1'b0, 160'h0},       // ignored byte inside a message
        '{8'h55, 1'b1, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b1, 160'h0},       // end without a byte
        '{8'hFF, 1'b1, 1'b1, 160'h0},       // one-byte message
        '{8'h00, 1'b1, 1'b1, 160'h0},
        '{8'h00, 1'b0, 1'b1,                // empty again: chaining words restored
          160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
        '{8'h80, 1'b1, 1'b1, 160'h0}
    };

    sha1_message_digest u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void reset_chain();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        msg_len    = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                wt = rol32(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
                w[r%16] = wt;
            end
            else
                wt = w[r];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Track one accepted request; on an end request queue the five digest words.
    function automatic void sha1_predict_item(input logic [7:0] d, input logic h,
                                              input logic e, input logic [159:0] want);
        int pos;
        int i;
        logic [63:0] nbits;
        digest_word_t dw;
        if (h)
        begin
            blk_buf[msg_len[5:0]] = d;
            msg_len = msg_len + 1'b1;
            if (msg_len[5:0] == 6'd0)
                sha1_compress();
        end
        if (!e)
            return;
        pos = int'(msg_len[5:0]);
        blk_buf[pos] = 8'h80;
        for (i = pos + 1; i < 64; i++)
            blk_buf[i] = 8'h00;
        // no room for the length: one extra block
        if (pos >= 56)
        begin
            sha1_compress();
            for (i = 0; i < 56; i++)
                blk_buf[i] = 8'h00;
        end
        nbits = {msg_len, 3'b000};
        for (i = 0; i < 8; i++)
            blk_buf[63 - i] = nbits[8*i +: 8];
        sha1_compress();
        for (i = 0; i < 5; i++)
        begin
            dw.word = (want != '0) ? want[159 - 32*i -: 32] : chain_h[i];
            dw.idx  = 3'(i);
            dw.last = (i == 4);
            digest_q.push_back(dw);
        end
        reset_chain();
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %0s: got %h, expected %h", $time, field, got, want);
        n_errors++;
    endtask

    task automatic send_item(input logic [7:0] d, input logic h, input logic e,
                             input logic [159:0] want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= d;
        s_tuser  <= h;
        s_tlast  <= e;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sha1_predict_item(d, h, e, want);
        n_items++;
    endtask

    task automatic send_message(input int len);
        bit carry_last;
        int n_body;
        int i;
        carry_last = (len > 0) && ($urandom_range(0, 1) == 1);
        n_body = carry_last ? len - 1 : len;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < n_body; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0, '0);
            send_item(8'($urandom), 1'b1, 1'b0, '0);
        end
        send_item(8'($urandom), carry_last, 1'b1, '0);
    endtask

    // Mostly short messages; some straddle the pad boundary, a few span two or three blocks.
    function automatic int pick_msg_len();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(0, 12);
        if (sel < 9)
            return $urandom_range(53, 66);
        return $urandom_range(117, 130);
    endfunction

    // watchdog: cycles without any accepted request on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("status: fail");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

    initial
    begin : rx_proc
        int gap;
        digest_word_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (n_words == HOLD_AT && !held)
            begin
                // long hold-off so the output register and then the input back up
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = rx_burst ? 0 : $urandom_range(0, 13);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            n_words++;
            if (n_words % 10 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest word", m_tdata[31:0], '0);
            else
            begin
                want = digest_q.pop_front();
                if (m_tdata[31:0] !== want.word)
                    report_mismatch("digest_word", m_tdata[31:0], want.word);
                if (m_tdata[34:32] !== want.idx)
                    report_mismatch("word_index", m_tdata[34:32], want.idx);
                if (m_tlast !== want.last)
                    report_mismatch("last_word", m_tlast, want.last);
            end
        end
    end

    initial
    begin : main_proc
        int i;
        reset_chain();
        for (i = 0; i < 64; i++)
            blk_buf[i] = 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIR; i++)
        begin
            tx_burst = (i >= 5 && i < 10);
            send_item(dir_tab[i].data, dir_tab[i].has, dir_tab[i].eom, dir_tab[i].want);
        end

        while (n_items < NUM_ITEMS)
            send_message(pick_msg_len());
        s_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sha1md_pkg.sv
rtl/core/sha1md_ctrl.sv
rtl/core/sha1md_dp.sv
rtl/core/sha1_message_digest.sv
tb/sv/testbench.sv
